[design/bss_pkg.sv]
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants for the bounded stack with ordered insert.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int unsigned DEPTH   = 20;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_REVERSE = 2'd2,
    CMD_ORDERED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                      command;
    logic signed [WORD_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  popped_value;
    status_e                   status;
    logic [COUNT_W-1:0]        entry_count;
  } out_t;

  typedef struct packed {
    logic fire;
    cmd_e op;
    logic rev;
    logic occ;
    logic at_fill;
  } cell_ctl_t;

endpackage

[design/bss_cell.sv]
// ----------------------------------------------------------------------------
// bss_cell
// One stack entry: holds a word, compares it against the incoming value and
// moves data from or to its neighbors.
// ----------------------------------------------------------------------------
module bss_cell import bss_pkg::*; (
  input  logic                     clk_i,
  input  cell_ctl_t                ctl_i,
  input  logic signed [WORD_W-1:0] value_i,
  input  logic signed [WORD_W-1:0] left_i,
  input  logic signed [WORD_W-1:0] right_i,
  input  logic                     pfx_i,
  input  logic                     sfx_i,
  input  logic                     left_sfx_i,
  output logic signed [WORD_W-1:0] data_o,
  output logic                     pfx_o,
  output logic                     sfx_o
);

  logic signed [WORD_W-1:0] data_q, data_d;
  logic                     gt;

  assign gt     = data_q > value_i;
  assign pfx_o  = pfx_i & ctl_i.occ & gt;
  assign sfx_o  = sfx_i & (~ctl_i.occ | gt);
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    if (ctl_i.fire) begin
      case (ctl_i.op)
        CMD_PUSH: begin
          if (!ctl_i.rev) begin
            data_d = left_i;
          end else if (ctl_i.at_fill) begin
            data_d = value_i;
          end
        end
        CMD_POP: begin
          if (!ctl_i.rev) begin
            data_d = right_i;
          end
        end
        CMD_ORDERED: begin
          if (!ctl_i.rev) begin
            if (pfx_o) begin
              data_d = data_q;
            end else if (pfx_i) begin
              data_d = value_i;
            end else begin
              data_d = left_i;
            end
          end else begin
            if (left_sfx_i) begin
              data_d = left_i;
            end else if (sfx_o) begin
              data_d = value_i;
            end
          end
        end
        default: begin
          data_d = data_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

[design/bounded_stack_sorted_insert.sv]
// ----------------------------------------------------------------------------
// bounded_stack_sorted_insert
// Bounded stack of signed words with push, pop, reverse and ordered push.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_data_i): one command and value per
//   transfer. out channel (out_valid_o/out_ready_i/out_data_o): exactly one
//   result per command, in order: popped word, status and new entry count.
//   out_valid_o rises in the cycle after the input transfer. One command per
//   cycle is taken unless the receiver stalls; the chain of entry cells updates in
//   parallel, with the ordered-push position found by a ripple through the cells.
//   Reverse flips the orientation of the cell row and moves no data.
//   A single output register separates the channels: while the receiver
//   stalls with a result pending, in_ready_o drops and the input holds;
//   a new command is taken in the same cycle the pending result transfers.
//   Reset empties the stack and drops any pending result; entry contents
//   are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module bounded_stack_sorted_insert import bss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic [CNT_W-1:0]         count_q, count_d;
  logic                     rev_q, rev_d;
  logic                     out_valid_q;
  out_t                     out_q, out_d;
  logic                     accept, move, full, empty;
  logic signed [WORD_W-1:0] top_word;
  logic signed [WORD_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]         occ, at_fill, top_sel;
  logic [DEPTH:0]           pfx, sfx;

  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign full   = count_q == CNT_W'(DEPTH);
  assign empty  = count_q == '0;
  assign pfx[0] = 1'b1;
  assign sfx[DEPTH] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t                ctl;
    logic signed [WORD_W-1:0] left_w, right_w;
    logic                     left_sfx;

    assign occ[i]     = count_q > CNT_W'(i);
    assign at_fill[i] = count_q == CNT_W'(i);

    if (i == 0) begin : g_first
      assign left_w   = in_data_i.value;
      assign left_sfx = 1'b0;
    end else begin : g_inner
      assign left_w   = cell_data[i-1];
      assign left_sfx = sfx[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w    = '0;
      assign top_sel[i] = occ[i];
    end else begin : g_body
      assign right_w    = cell_data[i+1];
      assign top_sel[i] = occ[i] & ~occ[i+1];
    end

    assign ctl.fire    = accept & move;
    assign ctl.op      = in_data_i.command;
    assign ctl.rev     = rev_q;
    assign ctl.occ     = occ[i];
    assign ctl.at_fill = at_fill[i];

    bss_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .value_i    (in_data_i.value),
      .left_i     (left_w),
      .right_i    (right_w),
      .pfx_i      (pfx[i]),
      .sfx_i      (sfx[i+1]),
      .left_sfx_i (left_sfx),
      .data_o     (cell_data[i]),
      .pfx_o      (pfx[i+1]),
      .sfx_o      (sfx[i])
    );
  end

  always_comb begin
    top_word = '0;
    if (!rev_q) begin
      top_word = cell_data[0];
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        top_word = top_word | (cell_data[i] & {WORD_W{top_sel[i]}});
      end
    end
  end

  always_comb begin
    move                 = 1'b0;
    count_d              = count_q;
    rev_d                = rev_q;
    out_d.popped_value   = '0;
    out_d.status         = ST_OK;
    case (in_data_i.command)
      CMD_PUSH, CMD_ORDERED: begin
        if (full) begin
          out_d.status = ST_FULL;
        end else begin
          move    = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          out_d.popped_value = '1;
          out_d.status       = ST_EMPTY;
        end else begin
          move               = 1'b1;
          count_d            = count_q - CNT_W'(1);
          out_d.popped_value = top_word;
        end
      end
      CMD_REVERSE: begin
        rev_d = ~rev_q;
      end
      default: begin
        move = 1'b0;
      end
    endcase
    out_d.entry_count = COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
        rev_q   <= rev_d;
      end
      if (in_ready_o) begin
        out_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

[tb/bounded_stack_sorted_insert_test.sv]
// ----------------------------------------------------------------------------
// bounded_stack_sorted_insert_test
// Self-checking testbench for the bounded stack with ordered insert.
// A queue-fed driver offers commands with random gaps. The receiver stalls at
// random and twice holds off long enough to back the block up. A monitor keeps
// a shadow stack of the entries, predicts each result as the command transfers
// and checks every returned result in order against that prediction.
// ----------------------------------------------------------------------------
module bounded_stack_sorted_insert_test;
  import bss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_CMDS = 1700;

  typedef struct {
    in_t         item;
    int unsigned gap;
    bit          drain;
  } stim_t;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  bounded_stack_sorted_insert dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  stim_t                    cmd_q[$];
  out_t                     expected_results[$];
  logic signed [WORD_W-1:0] shadow_words[DEPTH];
  int unsigned              shadow_fill = 0;
  int unsigned              outstanding = 0;
  int unsigned              tx_gap      = 0;
  int unsigned              rx_stall    = 0;
  int unsigned              rx_cycle    = 0;
  int unsigned              cycles      = 0;
  int unsigned              mismatches  = 0;
  int unsigned              results_checked = 0;
  int unsigned              cmd_seen[4] = '{default: 0};
  int unsigned              full_drops  = 0;
  int unsigned              empty_pops  = 0;
  int unsigned              peak_fill   = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Shadow stack: apply one command and return the result it should give.
  function automatic out_t stack_apply(in_t cmd);
    out_t                     res;
    int unsigned              pos;
    int unsigned              k;
    logic signed [WORD_W-1:0] tmp;
    res.popped_value = '0;
    res.status       = ST_OK;
    case (cmd.command)
      CMD_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[shadow_fill] = cmd.value;
          shadow_fill++;
        end
      end
      CMD_POP: begin
        if (shadow_fill == 0) begin
          res.popped_value = -32'sd1;
          res.status       = ST_EMPTY;
        end else begin
          shadow_fill--;
          res.popped_value = shadow_words[shadow_fill];
        end
      end
      CMD_REVERSE: begin
        for (k = 0; k < shadow_fill / 2; k++) begin
          tmp                              = shadow_words[k];
          shadow_words[k]                  = shadow_words[shadow_fill - 1 - k];
          shadow_words[shadow_fill - 1 - k] = tmp;
        end
      end
      default: begin
        if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pos = shadow_fill;
          while (pos > 0 && shadow_words[pos - 1] > $signed(cmd.value)) pos--;
          for (k = shadow_fill; k > pos; k--) shadow_words[k] = shadow_words[k - 1];
          shadow_words[pos] = cmd.value;
          shadow_fill++;
        end
      end
    endcase
    res.entry_count = COUNT_W'(shadow_fill);
    return res;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3, 4:    return $urandom_range(0, 8) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // Command mix per phase: 0 fill, 1 drain, 2 sorted build, 3 uniform.
  function automatic cmd_e pick_cmd(int unsigned phase);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (phase)
      0:       return r < 45 ? CMD_PUSH : r < 85 ? CMD_ORDERED : r < 95 ? CMD_POP : CMD_REVERSE;
      1:       return r < 75 ? CMD_POP : r < 85 ? CMD_REVERSE : r < 93 ? CMD_PUSH : CMD_ORDERED;
      2:       return r < 80 ? CMD_ORDERED : r < 95 ? CMD_POP : CMD_REVERSE;
      default: return cmd_e'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic add_cmd(cmd_e op, logic [WORD_W-1:0] val, int unsigned gap);
    stim_t s;
    s.item.command = op;
    s.item.value   = val;
    s.gap          = gap;
    s.drain        = 1'b0;
    cmd_q.push_back(s);
  endtask

  task automatic add_drain();
    stim_t s;
    s.item  = '0;
    s.gap   = 0;
    s.drain = 1'b1;
    cmd_q.push_back(s);
  endtask

  task automatic note_mismatch(string what, out_t want, out_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch (%s): expected value %0d status %s count %0d,",
               $realtime, what, want.popped_value, want.status.name(), want.entry_count);
      $display("    got value %0d status %s count %0d",
               seen.popped_value, seen.status.name(), seen.entry_count);
    end
  endtask

  // Driver: offer the next queued command once the current one has transferred.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (tx_gap > 0) begin
        tx_gap     <= tx_gap - 1;
        in_valid_i <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (cmd_q[0].drain) begin
        in_valid_i <= 1'b0;
        if (!in_valid_i && outstanding == 0) void'(cmd_q.pop_front());
      end else begin
        in_valid_i <= 1'b1;
        in_data_i  <= cmd_q[0].item;
        tx_gap     <= cmd_q[0].gap;
        void'(cmd_q.pop_front());
      end
    end
  end

  // Receiver: random stalls, calm stretches, and long hold-offs to back up the block.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if ((rx_cycle >= 1500 && rx_cycle < 1700) || (rx_cycle >= 5000 && rx_cycle < 5300)) begin
        out_ready_i <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall    <= rx_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (rx_cycle[8] && $urandom_range(0, 99) < 25) rx_stall <= gap_len();
      end
    end
  end

  // Monitor: predict on each command transfer, then check each result transfer.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        want = stack_apply(in_data_i);
        expected_results.push_back(want);
        cmd_seen[in_data_i.command]++;
        if (want.status == ST_FULL) full_drops++;
        if (want.status == ST_EMPTY) empty_pops++;
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result", '0, out_data_o);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_data_o.popped_value !== want.popped_value || out_data_o.status !== want.status
              || out_data_o.entry_count !== want.entry_count) begin
            note_mismatch("wrong field", want, out_data_o);
          end
        end
      end
      outstanding <= expected_results.size();
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned phase;
    int unsigned run;
    int unsigned i;
    bit          calm;

    // Directed opening: empty stack, single entry, extremes, equal-value insert.
    add_cmd(CMD_POP,     32'h1234_5678, 0);
    add_cmd(CMD_REVERSE, 32'hFFFF_FFFF, 0);
    add_cmd(CMD_PUSH,    32'h7FFF_FFFF, 0);
    add_cmd(CMD_REVERSE, 32'h0000_0000, 1);
    add_cmd(CMD_POP,     32'h8000_0000, 0);
    add_cmd(CMD_POP,     32'h0000_0000, 0);
    add_cmd(CMD_PUSH,    32'h8000_0000, 0);
    add_cmd(CMD_PUSH,    32'h7FFF_FFFF, 2);
    add_cmd(CMD_PUSH,    32'hFFFF_FFFF, 0);
    add_cmd(CMD_PUSH,    32'h0000_0000, 0);
    add_cmd(CMD_ORDERED, 32'h0000_0005, 0);
    add_cmd(CMD_ORDERED, 32'hFFFF_FFFE, 0);
    add_cmd(CMD_ORDERED, 32'hFFFF_FFFF, 3);
    add_cmd(CMD_ORDERED, 32'h8000_0000, 0);
    add_cmd(CMD_ORDERED, 32'h7FFF_FFFF, 0);
    add_cmd(CMD_REVERSE, 32'h5555_5555, 0);
    add_cmd(CMD_ORDERED, 32'h0000_0000, 0);
    add_cmd(CMD_POP,     32'hAAAA_AAAA, 0);
    add_cmd(CMD_REVERSE, 32'h0000_0000, 0);
    add_cmd(CMD_POP,     32'h0000_0000, 0);
    add_drain();

    n = 0;
    while (n < RANDOM_CMDS) begin
      phase = $urandom_range(0, 3);
      run   = $urandom_range(10, 60);
      calm  = ($urandom_range(0, 3) == 0);
      for (i = 0; i < run; i++) begin
        add_cmd(pick_cmd(phase), pick_value(), calm ? 0 : gap_len());
      end
      if ((n / 400) != ((n + run) / 400)) add_drain();
      n += run;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (cmd_q.size() != 0 || in_valid_i || outstanding != 0);
    repeat (8) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      mismatches += expected_results.size();
      $display("%0d results never arrived", expected_results.size());
    end
    $display("Covered %0d push, %0d pop, %0d reverse, %0d ordered push; peak fill %0d of %0d",
             cmd_seen[CMD_PUSH], cmd_seen[CMD_POP], cmd_seen[CMD_REVERSE],
             cmd_seen[CMD_ORDERED], peak_fill, DEPTH);
    $display("Checked %0d results (%0d full drops, %0d empty pops), %0d mismatches",
             results_checked, full_drops, empty_pops, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
